// ===== rtl/rgbc_pkg.sv =====
// Shared types and constants of the 3x3 RGB convolution filter.
package rgbc_pkg;

    // Geometry limits of the line memory and the frame counters.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int DIV_W      = 10;
    localparam int KROW_W     = 24;
    localparam int PIX_W      = 24;
    localparam int TAPS       = 9;
    localparam int TAP_W      = $clog2(TAPS);
    localparam int ACC_W      = 20;
    localparam int REM_W      = 18;
    localparam logic [7:0] PIX_MAX = 8'd255;

    // APB register window.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register index codes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_DIVISOR       = 3'd3,
        REG_FRAME_WIDTH   = 3'd4,
        REG_FRAME_HEIGHT  = 3'd5
    } t_reg_index;

    // Input request payload: one raster pixel.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel_in;

    // Output request payload: one filtered interior pixel.
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic             frame_done;
    } t_result_out;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_MAC   = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

// ===== rtl/rgb_convolution_3x3.sv =====
// 3x3 RGB convolution with divisor and clamp, built around one line memory.
// One pixel is in work at a time: a new request is taken only in idle. An interior pixel
// runs the nine-tap multiply-accumulate loop and the eight-step quotient loop, then waits
// for the output register; a border pixel only does the line memory read and write.
// Reset (synchronous, active low) restores the registers, counters and window to their
// defaults; the line memory is not cleared and holds unknown data until first written.
module rgb_convolution_3x3 import rgbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pixel_in         i_in_pixel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result_out       o_out_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers.
    logic [KROW_W-1:0] r_kernel_top;
    logic [KROW_W-1:0] r_kernel_mid;
    logic [KROW_W-1:0] r_kernel_bot;
    logic [DIV_W-1:0]  r_divisor;
    logic [WID_W-1:0]  r_frame_width;
    logic [HGT_W-1:0]  r_frame_height;

    // Sequencer and position state.
    t_state            r_state;
    logic [COL_W-1:0]  r_col_cnt;
    logic [ROW_W-1:0]  r_row_cnt;
    logic [TAP_W-1:0]  r_tap;
    logic [2:0]        r_step;
    logic [PIX_W-1:0]  r_win [TAPS];

    // Item being worked on.
    logic [PIX_W-1:0]  r_item_pix;
    logic [COL_W-1:0]  r_item_col;
    logic [ROW_W-1:0]  r_item_row_out;
    logic [COL_W-1:0]  r_item_col_out;
    logic              r_item_emit;
    logic              r_item_done;

    // Per-channel arithmetic.
    logic signed [ACC_W-1:0] r_acc [3];
    logic [REM_W-1:0]        r_rem [3];
    logic [7:0]              r_quo [3];

    // Output register.
    logic        r_out_valid;
    t_result_out r_out;

    // Line memory: each entry holds {upper row pixel, lower row pixel} of one column.
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_line_rd;

    logic              in_acc;
    logic              cfg_wr;
    logic [2:0]        reg_idx;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [DIV_W-1:0]  div_eff;
    logic [WID_W-1:0]  col_inc;
    logic [HGT_W-1:0]  row_inc;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic              emit;
    logic              last_pix;
    logic [PIX_W-1:0]  tap_pix;
    logic signed [7:0] tap_coef;
    logic signed [16:0] prod [3];
    logic [REM_W-1:0]  d_shift;
    logic              out_load;

    // Handshake outputs.
    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;
    assign pready       = 1'b1;
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Register decode.
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_top   <= '0;
            r_kernel_mid   <= KROW_W'(256);
            r_kernel_bot   <= '0;
            r_divisor      <= DIV_W'(1);
            r_frame_width  <= WID_W'(MAX_WIDTH);
            r_frame_height <= HGT_W'(1024);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KERNEL_TOP:    r_kernel_top   <= pwdata[KROW_W-1:0];
                REG_KERNEL_MIDDLE: r_kernel_mid   <= pwdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: r_kernel_bot   <= pwdata[KROW_W-1:0];
                REG_DIVISOR:       r_divisor      <= pwdata[DIV_W-1:0];
                REG_FRAME_WIDTH:   r_frame_width  <= pwdata[WID_W-1:0];
                REG_FRAME_HEIGHT:  r_frame_height <= pwdata[HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_KERNEL_TOP:    prdata = DATA_W'(r_kernel_top);
            REG_KERNEL_MIDDLE: prdata = DATA_W'(r_kernel_mid);
            REG_KERNEL_BOTTOM: prdata = DATA_W'(r_kernel_bot);
            REG_DIVISOR:       prdata = DATA_W'(r_divisor);
            REG_FRAME_WIDTH:   prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT:  prdata = DATA_W'(r_frame_height);
            default:           prdata = '0;
        endcase
    end

    // Effective geometry and divisor, saturated to their legal ranges.
    always_comb begin
        if (r_frame_width < WID_W'(MIN_DIM)) begin
            w_eff = WID_W'(MIN_DIM);
        end else if (r_frame_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < HGT_W'(MIN_DIM)) begin
            h_eff = HGT_W'(MIN_DIM);
        end else if (r_frame_height > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        div_eff = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    end

    // Next raster position and the result rule for the incoming pixel.
    always_comb begin
        col_inc = {1'b0, r_col_cnt} + WID_W'(1);
        row_inc = {1'b0, r_row_cnt} + HGT_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row_cnt;
        end
        emit     = (r_row_cnt >= ROW_W'(2)) && (r_col_cnt >= COL_W'(2));
        last_pix = ({1'b0, r_row_cnt} == h_eff - HGT_W'(1)) &&
                   ({1'b0, r_col_cnt} == w_eff - WID_W'(1));
    end

    // Line memory: read at request, write back the shifted column in the cycle after.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_rd <= r_line_mem[r_col_cnt];
        end
        if (r_state == S_READ) begin
            r_line_mem[r_item_col] <= {r_line_rd[PIX_W-1:0], r_item_pix};
        end
    end

    // Tap selection for the multiply-accumulate loop.
    always_comb begin
        tap_pix = r_win[r_tap];
        case (r_tap)
            TAP_W'(0): tap_coef = r_kernel_top[7:0];
            TAP_W'(1): tap_coef = r_kernel_top[15:8];
            TAP_W'(2): tap_coef = r_kernel_top[23:16];
            TAP_W'(3): tap_coef = r_kernel_mid[7:0];
            TAP_W'(4): tap_coef = r_kernel_mid[15:8];
            TAP_W'(5): tap_coef = r_kernel_mid[23:16];
            TAP_W'(6): tap_coef = r_kernel_bot[7:0];
            TAP_W'(7): tap_coef = r_kernel_bot[15:8];
            TAP_W'(8): tap_coef = r_kernel_bot[23:16];
            default:   tap_coef = '0;
        endcase
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = $signed({1'b0, tap_pix[8*ch +: 8]}) * tap_coef;
        end
        d_shift = REM_W'(div_eff) << r_step;
    end

    // Sequencer, position counters and the pixel window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_tap     <= '0;
            r_step    <= '0;
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col_cnt <= n_col;
                        r_row_cnt <= n_row;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[3*i]   <= r_win[3*i+1];
                        r_win[3*i+1] <= r_win[3*i+2];
                    end
                    r_win[2] <= r_line_rd[2*PIX_W-1:PIX_W];
                    r_win[5] <= r_line_rd[PIX_W-1:0];
                    r_win[8] <= r_item_pix;
                    r_tap    <= '0;
                    r_state  <= r_item_emit ? S_MAC : S_IDLE;
                end
                S_MAC: begin
                    r_tap <= r_tap + TAP_W'(1);
                    if (r_tap == TAP_W'(TAPS - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_step  <= 3'd7;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item capture and per-channel arithmetic.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item_pix     <= {i_in_pixel.blue_in, i_in_pixel.green_in, i_in_pixel.red_in};
            r_item_col     <= r_col_cnt;
            r_item_row_out <= r_row_cnt - ROW_W'(1);
            r_item_col_out <= r_col_cnt - COL_W'(1);
            r_item_emit    <= emit;
            r_item_done    <= last_pix;
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (r_state == S_READ) begin
                r_acc[ch] <= '0;
            end else if (r_state == S_MAC) begin
                r_acc[ch] <= r_acc[ch] + {{(ACC_W-17){prod[ch][16]}}, prod[ch]};
            end
            // Negative sums clamp to zero, sums of 256 divisors or more clamp to the top.
            if (r_state == S_CHECK) begin
                if (r_acc[ch][ACC_W-1] || (r_acc[ch] == '0)) begin
                    r_quo[ch] <= '0;
                    r_rem[ch] <= '0;
                end else if (r_acc[ch][ACC_W-2:0] >= {1'b0, div_eff, 8'b0}) begin
                    r_quo[ch] <= PIX_MAX;
                    r_rem[ch] <= '0;
                end else begin
                    r_quo[ch] <= '0;
                    r_rem[ch] <= r_acc[ch][REM_W-1:0];
                end
            end else if (r_state == S_DIV) begin
                if (r_rem[ch] >= d_shift) begin
                    r_rem[ch]         <= r_rem[ch] - d_shift;
                    r_quo[ch][r_step] <= 1'b1;
                end
            end
        end
    end

    // Output register: holds a finished result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_row    <= r_item_row_out;
            r_out.out_col    <= r_item_col_out;
            r_out.red_out    <= r_quo[0];
            r_out.green_out  <= r_quo[1];
            r_out.blue_out   <= r_quo[2];
            r_out.frame_done <= r_item_done;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished result reaches the output register and frees the sequencer.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished result was not loaded into the output register");

    // In division the red channel remainder stays below the divisor shifted one step up.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |->
            ({1'b0, r_rem[0]} < ((REM_W+1)'(div_eff) << ({1'b0, r_step} + 4'd1))))
        else $error("quotient step remainder out of bound");

    // A border pixel releases the sequencer right after the line memory update.
    a_border_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !emit) |-> ##2 (r_state == S_IDLE))
        else $error("border pixel did not return to idle");

    // Results only ever describe interior pixels.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_result.out_row != '0) && (o_out_result.out_col != '0)))
        else $error("result reported for a border position");
`endif

endmodule

// ===== tb/rgb_convolution_3x3_tb.sv =====
// Self-checking testbench for the 3x3 RGB convolution filter with divisor and clamp.
`timescale 1ns / 100ps

module rgb_convolution_3x3_tb;
    import rgbc_pkg::*;

    // Run limits: drain margin, watchdog limit, random pixel count and failure report cap.
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 300_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int REPORT_LIMIT = 10;

    // Directed pixel set: extremes, alternating bit patterns, mid-scale and mixed values.
    localparam logic [23:0] PATTERN [9] = '{
        24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0, 24'hAA55FF,
        24'h123456, 24'h808080, 24'h7F7F7F, 24'h010203
    };

    // One pixel as three channels; index 0 is red, 1 green, 2 blue.
    typedef logic [2:0][7:0] t_rgb;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_pixel_in         i_in_pixel = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_result_out       o_out_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow copy of the configuration registers, at their reset values.
    logic [KROW_W-1:0] kernel_rows [3] = '{24'h000000, 24'h000100, 24'h000000};
    logic [DIV_W-1:0]  divisor_reg = 10'd1;
    logic [WID_W-1:0]  width_reg = 11'd1024;
    logic [HGT_W-1:0]  height_reg = 13'd1024;

    // Filter state: two line stores, the 3x3 window and the raster position.
    t_rgb upper_line [MAX_WIDTH];
    t_rgb lower_line [MAX_WIDTH];
    t_rgb win [3][3];
    int   col_pos = 0;
    int   row_pos = 0;

    // Filtered pixels still owed by the block, oldest first.
    t_result_out expected_results [$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int failures = 0;
    int items_sent = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int cycle_count = 0;

    rgb_convolution_3x3 i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_pixel   (i_in_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_result (o_out_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side back-pressure: random stall bursts, started only while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Counts a failure and tells whether it should still be printed.
    function automatic bit log_failure();
        failures++;
        return failures <= REPORT_LIMIT;
    endfunction

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // Weighted sum of one channel over the window, divided toward zero and clamped.
    function automatic logic [7:0] filter_channel(int ch);
        int acc;
        int d;
        int q;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc += int'(win[i][j][ch]) * int'($signed(kernel_rows[i][8*j +: 8]));
            end
        end
        d = (divisor_reg == '0) ? 1 : int'(divisor_reg);
        q = acc / d;
        if (q < 0) q = 0;
        if (q > int'(PIX_MAX)) q = int'(PIX_MAX);
        return q[7:0];
    endfunction

    // Advances the filter state by one pixel and queues the filtered pixel it yields.
    function automatic void convolve_pixel(t_pixel_in px);
        t_rgb        cur;
        t_rgb        up;
        t_rgb        lo;
        t_result_out res;
        int          w;
        int          h;
        w = eff_width();
        h = eff_height();
        cur = {px.blue_in, px.green_in, px.red_in};
        up = upper_line[col_pos];
        lo = lower_line[col_pos];
        upper_line[col_pos] = lo;
        lower_line[col_pos] = cur;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = cur;

        // Only a window centered on an interior pixel gives a result.
        if (row_pos >= 2 && col_pos >= 2) begin
            res.out_row    = ROW_W'(row_pos - 1);
            res.out_col    = COL_W'(col_pos - 1);
            res.red_out    = filter_channel(0);
            res.green_out  = filter_channel(1);
            res.blue_out   = filter_channel(2);
            res.frame_done = (row_pos == h - 1) && (col_pos == w - 1);
            expected_results.push_back(res);
        end

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    // Compare every accepted result with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_result_out want;
        t_result_out got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_result;
            if (expected_results.size() == 0) begin
                if (log_failure()) begin
                    $display("Unexpected result: row %0d col %0d rgb %02h %02h %02h done %0b",
                             got.out_row, got.out_col, got.red_out, got.green_out,
                             got.blue_out, got.frame_done);
                end
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                    got.red_out !== want.red_out || got.green_out !== want.green_out ||
                    got.blue_out !== want.blue_out || got.frame_done !== want.frame_done) begin
                    if (log_failure()) begin
                        $display("Mismatch: expected row %0d col %0d rgb %02h %02h %02h done %0b",
                                 want.out_row, want.out_col, want.red_out, want.green_out,
                                 want.blue_out, want.frame_done);
                        $display("          actual   row %0d col %0d rgb %02h %02h %02h done %0b",
                                 got.out_row, got.out_col, got.red_out, got.green_out,
                                 got.blue_out, got.frame_done);
                    end
                end
            end
        end
    end

    // One APB transfer: setup, access until pready, then back to idle.
    task automatic apb_transfer(input bit wr, input t_reg_index idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes a register and updates the shadow copy with the bits it keeps.
    task automatic write_reg(input t_reg_index idx, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] unused;
        apb_transfer(1'b1, idx, data, unused);
        case (idx)
            REG_KERNEL_TOP:    kernel_rows[0] = data[KROW_W-1:0];
            REG_KERNEL_MIDDLE: kernel_rows[1] = data[KROW_W-1:0];
            REG_KERNEL_BOTTOM: kernel_rows[2] = data[KROW_W-1:0];
            REG_DIVISOR:       divisor_reg = data[DIV_W-1:0];
            REG_FRAME_WIDTH:   width_reg = data[WID_W-1:0];
            REG_FRAME_HEIGHT:  height_reg = data[HGT_W-1:0];
            default: ;
        endcase
    endtask

    // Reads a register back and compares it with the shadow copy.
    task automatic check_reg(input t_reg_index idx);
        logic [DATA_W-1:0] got;
        logic [DATA_W-1:0] want;
        apb_transfer(1'b0, idx, '0, got);
        case (idx)
            REG_KERNEL_TOP:    want = DATA_W'(kernel_rows[0]);
            REG_KERNEL_MIDDLE: want = DATA_W'(kernel_rows[1]);
            REG_KERNEL_BOTTOM: want = DATA_W'(kernel_rows[2]);
            REG_DIVISOR:       want = DATA_W'(divisor_reg);
            REG_FRAME_WIDTH:   want = DATA_W'(width_reg);
            REG_FRAME_HEIGHT:  want = DATA_W'(height_reg);
            default:           want = '0;
        endcase
        if (got !== want) begin
            if (log_failure()) begin
                $display("Register %s read back: expected %08h, actual %08h",
                         idx.name(), want, got);
            end
        end
    endtask

    // Sends one pixel request, with an optional gap before it.
    task automatic send_pixel(input t_pixel_in px);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_pixel <= px;
        do @(posedge i_clk); while (!o_in_ready);
        convolve_pixel(px);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops the pixel stream and waits until the block has gone quiet.
    task automatic drain_stream();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_pixel_in random_pixel();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            default: return t_pixel_in'(24'($urandom()));
        endcase
    endfunction

    // Mild rows keep sums in range so that the divider shows; full rows span -128..127.
    function automatic logic [KROW_W-1:0] random_kernel_row(bit mild);
        logic [KROW_W-1:0] row;
        int                tmp;
        for (int j = 0; j < 3; j++) begin
            tmp = mild ? int'($urandom_range(0, 8)) - 4 : int'($urandom_range(0, 255));
            row[8*j +: 8] = tmp[7:0];
        end
        return row;
    endfunction

    // New kernel and divisor; the upper data bits carry noise the block must ignore.
    task automatic retune_filter();
        bit mild;
        int dv;
        mild = ($urandom_range(0, 2) != 0);
        write_reg(REG_KERNEL_TOP,    {8'($urandom()), random_kernel_row(mild)});
        write_reg(REG_KERNEL_MIDDLE, {8'($urandom()), random_kernel_row(mild)});
        write_reg(REG_KERNEL_BOTTOM, {8'($urandom()), random_kernel_row(mild)});
        case ($urandom_range(0, 9))
            0: dv = 0;
            1: dv = 1023;
            2: dv = 1;
            default: dv = mild ? $urandom_range(1, 6) : $urandom_range(1, 1023);
        endcase
        write_reg(REG_DIVISOR, {22'($urandom()), 10'(dv)});
    endtask

    task automatic set_geometry(input int w, input int h);
        drain_stream();
        write_reg(REG_FRAME_WIDTH,  {21'($urandom()), 11'(w)});
        write_reg(REG_FRAME_HEIGHT, {19'($urandom()), 13'(h)});
    endtask

    // One whole frame of random pixels; optionally the filter is retuned partway.
    task automatic send_frame(input bit retune);
        int total;
        int cut;
        total = eff_width() * eff_height();
        cut = retune ? $urandom_range(1, total - 1) : -1;
        for (int n = 0; n < total; n++) begin
            if (n == cut) begin
                drain_stream();
                retune_filter();
            end
            send_pixel(random_pixel());
        end
        frames_sent++;
    endtask

    // Registers read back their reset values.
    task automatic test_reset_values();
        t_reg_index idx;
        idx = idx.first();
        do begin
            check_reg(idx);
            idx = idx.next();
        end while (idx != idx.first());
    endtask

    // Small frames: identity kernel from reset, then clamping at both ends.
    task automatic test_directed_frames();
        set_geometry(MIN_DIM, MIN_DIM);
        foreach (PATTERN[k]) send_pixel(t_pixel_in'(PATTERN[k]));
        frames_sent++;

        // Largest positive coefficients saturate at the top.
        drain_stream();
        write_reg(REG_KERNEL_TOP, 32'h007F7F7F);
        write_reg(REG_KERNEL_MIDDLE, 32'h007F7F7F);
        write_reg(REG_KERNEL_BOTTOM, 32'h007F7F7F);
        write_reg(REG_DIVISOR, 32'd1);
        foreach (PATTERN[k]) send_pixel(t_pixel_in'(PATTERN[k]));
        frames_sent++;

        // Most negative coefficients with the largest divisor clamp at zero.
        drain_stream();
        write_reg(REG_KERNEL_TOP, 32'h00808080);
        write_reg(REG_KERNEL_MIDDLE, 32'h00808080);
        write_reg(REG_KERNEL_BOTTOM, 32'h00808080);
        write_reg(REG_DIVISOR, 32'd1023);
        foreach (PATTERN[k]) send_pixel(t_pixel_in'(PATTERN[k]));
        frames_sent++;
    endtask

    // Complementary patterns toggle every register bit; noise above each field is dropped.
    task automatic test_register_access();
        t_reg_index idx;
        drain_stream();
        idx = idx.first();
        do begin
            write_reg(idx, 32'hA5A5A5A5);
            check_reg(idx);
            write_reg(idx, 32'h5A5A5A5A);
            check_reg(idx);
            idx = idx.next();
        end while (idx != idx.first());
    endtask

    // Zero divisor and geometry values below the legal range.
    task automatic test_out_of_range_settings();
        set_geometry(0, 1);
        retune_filter();
        write_reg(REG_DIVISOR, 32'd0);
        send_frame(1'b0);
        set_geometry(2, 0);
        retune_filter();
        send_frame(1'b1);
    endtask

    // Random small frames with random filters; the last part runs without idling.
    task automatic test_random_frames();
        int start;
        int w;
        int h;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - start > RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 4) != 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2);
            set_geometry(w, h);
            retune_filter();
            send_frame($urandom_range(0, 3) == 0);
        end
        idle_on = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed_frames();
        test_register_access();
        test_out_of_range_settings();
        test_random_frames();
        drain_stream();

        $display("Streamed %0d pixels in %0d frames and checked %0d filtered pixels.",
                 items_sent, frames_sent, results_checked);
        $display("Frames ran from 3x3 up to 64 wide, with clamping, zero divisor,");
        $display("undersized geometry and bursty traffic on both sides; %0d failures.",
                 failures);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rgbc_pkg.sv
rtl/rgb_convolution_3x3.sv
tb/rgb_convolution_3x3_tb.sv
